// ===== rtl/trie_word_insert_search_assert.svh =====
// Assertion macros used by the checker file.
`ifndef TRIE_WORD_INSERT_SEARCH_ASSERT_SVH
`define TRIE_WORD_INSERT_SEARCH_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TWIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define TWIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/twis_pkg.sv =====
package twis_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int ALPHABET   = 62;

  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int USED_W  = $clog2(NODE_COUNT + 1);
  localparam int SLOTS   = NODE_COUNT * ALPHABET;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int EDGE_W  = $clog2(ALPHABET);
  // Edge entry: {child is a word end, child node id}
  localparam int ENTRY_W = NODE_W + 1;

  localparam int DIGITS     = 10;
  localparam int LOWER_BASE = 36;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADCHAR = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_e;

  typedef struct packed {
    op_e        opcode;
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic    found;
    status_e status;
    logic    word_end;
  } out_t;

  typedef struct packed {
    logic              ok;
    logic [EDGE_W-1:0] idx;
  } edge_t;

  function automatic edge_t edge_of(logic [7:0] c);
    edge_t r;
    r.ok  = 1'b1;
    r.idx = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r.idx = EDGE_W'(c - CH_ZERO);
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r.idx = EDGE_W'(c - CH_UPPER_A) + EDGE_W'(DIGITS);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      r.idx = EDGE_W'(c - CH_LOWER_A) + EDGE_W'(LOWER_BASE);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/twis_ram.sv =====
module twis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/trie_word_insert_search.sv =====
// An accepted item is held in the payload registers while its edge entry is read; the result
// is written to the output register as the lookup state ends, and no new item is taken until then.
// Reset: rst_ni clears control state at once, then a clearing pass writes zero to all
// NODE_COUNT*ALPHABET edge entries while in_stall_o is high.
// After the pass the trie holds only the root.
module trie_word_insert_search (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  twis_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output twis_pkg::out_t out_o
);

  // Edge table: one entry per (node, character). Each entry holds the child id and
  // the child's word-end flag; a node has a single parent edge, so its word-end
  // bit lives there and one read answers both questions.

  twis_pkg::state_e state_q, state_d;

  logic [twis_pkg::SLOT_W-1:0] clr_q, clr_d;
  logic                        clr_last;

  // Trie walk state
  logic [twis_pkg::NODE_W-1:0] cursor_q, cursor_d;
  logic [twis_pkg::USED_W-1:0] used_q, used_d;
  logic                        failed_q, failed_d;
  twis_pkg::status_e           code_q, code_d;

  // Item held while its edge entry is read
  twis_pkg::op_e               op_q;
  logic                        last_q;
  logic                        bad_q;
  logic [twis_pkg::SLOT_W-1:0] slot_q;

  // Output register
  logic           out_valid_q, out_valid_d;
  twis_pkg::out_t out_q, out_d;

  // RAM ports
  logic                         ram_we;
  logic [twis_pkg::SLOT_W-1:0]  ram_waddr;
  logic [twis_pkg::ENTRY_W-1:0] ram_wdata;
  logic [twis_pkg::SLOT_W-1:0]  ram_raddr;
  logic [twis_pkg::ENTRY_W-1:0] ram_rdata;

  logic                         accept;
  twis_pkg::edge_t              in_edge;
  logic [twis_pkg::NODE_W-1:0]  child;
  logic                         child_end;
  logic                         look_we;
  logic [twis_pkg::ENTRY_W-1:0] look_wdata;

  twis_ram #(
    .WIDTH (twis_pkg::ENTRY_W),
    .DEPTH (twis_pkg::SLOTS)
  ) u_edges (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign clr_last  = (clr_q == twis_pkg::SLOT_W'(twis_pkg::SLOTS - 1));
  assign accept    = in_valid_i && !in_stall_o;
  assign in_edge   = twis_pkg::edge_of(in_i.char_code);
  // Read address: edge slot of the current node; valid since the cursor is final
  // by the time the previous item leaves the lookup state.
  assign ram_raddr = twis_pkg::SLOT_W'(twis_pkg::SLOT_W'(cursor_q) *
                     twis_pkg::SLOT_W'(twis_pkg::ALPHABET)) + twis_pkg::SLOT_W'(in_edge.idx);
  assign child     = ram_rdata[twis_pkg::NODE_W-1:0];
  assign child_end = ram_rdata[twis_pkg::NODE_W];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      twis_pkg::S_CLEAR: begin
        if (clr_last) state_d = twis_pkg::S_IDLE;
      end
      twis_pkg::S_IDLE: begin
        if (accept) state_d = twis_pkg::S_LOOK;
      end
      twis_pkg::S_LOOK: begin
        state_d = twis_pkg::S_IDLE;
      end
      default: state_d = twis_pkg::S_CLEAR;
    endcase
  end

  // State outputs: stall and RAM write port
  always_comb begin
    in_stall_o = 1'b1;
    ram_we     = 1'b0;
    ram_waddr  = slot_q;
    ram_wdata  = look_wdata;
    case (state_q)
      twis_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      twis_pkg::S_IDLE: begin
        // Take an item only if the output register is free by the next edge
        in_stall_o = out_valid_q && out_stall_i;
      end
      twis_pkg::S_LOOK: begin
        ram_we = look_we;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Lookup: resolve the edge entry, update the walk, build the result; also step the clear counter
  always_comb begin
    cursor_d   = cursor_q;
    used_d     = used_q;
    failed_d   = failed_q;
    code_d     = code_q;
    look_we    = 1'b0;
    look_wdata = {1'b1, child};
    out_d      = out_q;
    clr_d      = clr_q;

    if (state_q == twis_pkg::S_CLEAR) begin
      clr_d = clr_q + twis_pkg::SLOT_W'(1);
    end

    if (state_q == twis_pkg::S_LOOK) begin
      out_d.found    = 1'b0;
      out_d.status   = twis_pkg::ST_OK;
      out_d.word_end = last_q;

      if (failed_q) begin
        // Drop the rest of a failed word, repeating its code
        out_d.status = code_q;
      end else if (bad_q) begin
        failed_d     = 1'b1;
        code_d       = twis_pkg::ST_BADCHAR;
        out_d.status = twis_pkg::ST_BADCHAR;
      end else if (op_q == twis_pkg::OP_INSERT) begin
        if (child == '0) begin
          if (used_q >= twis_pkg::USED_W'(twis_pkg::NODE_COUNT)) begin
            failed_d     = 1'b1;
            code_d       = twis_pkg::ST_FULL;
            out_d.status = twis_pkg::ST_FULL;
          end else begin
            // Allocate the next pool node; its word-end flag is written with it
            look_we    = 1'b1;
            look_wdata = {last_q, used_q[twis_pkg::NODE_W-1:0]};
            cursor_d   = used_q[twis_pkg::NODE_W-1:0];
            used_d     = used_q + twis_pkg::USED_W'(1);
          end
        end else begin
          cursor_d = child;
          // Mark an existing node as a word end
          if (last_q && !child_end) look_we = 1'b1;
        end
      end else begin
        if (child == '0) begin
          // Search miss: no error, just skip the rest of the word
          failed_d = 1'b1;
          code_d   = twis_pkg::ST_OK;
        end else begin
          cursor_d    = child;
          out_d.found = last_q && child_end;
        end
      end

      if (last_q) begin
        cursor_d = '0;
        failed_d = 1'b0;
        code_d   = twis_pkg::ST_OK;
      end
    end
  end

  // Output register is always free in the lookup state (see stall above)
  assign out_valid_d = (state_q == twis_pkg::S_LOOK) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= twis_pkg::S_CLEAR;
      clr_q       <= '0;
      cursor_q    <= '0;
      used_q      <= twis_pkg::USED_W'(1);
      failed_q    <= 1'b0;
      code_q      <= twis_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cursor_q    <= cursor_d;
      used_q      <= used_d;
      failed_q    <= failed_d;
      code_q      <= code_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold the accepted item and the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_i.opcode;
      last_q <= in_i.last_char;
      bad_q  <= !in_edge.ok;
      slot_q <= ram_raddr;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/twis_checker.sv =====
`include "trie_word_insert_search_assert.svh"

module twis_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input twis_pkg::out_t out_o
);

  logic in_acc;
  logic out_wait;
  logic found_seen;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_wait   = out_valid_o && out_stall_i;
  assign found_seen = out_valid_o && out_o.found;

  `TWIS_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o && $stable(out_o), "stalled item changed")
  `TWIS_ASSERT_NEXT(a_look_busy, in_acc, in_stall_o && !out_valid_o, "item taken during lookup")
  `TWIS_ASSERT_NOW(a_found_last, found_seen, out_o.word_end, "found before the end of a word")
  `TWIS_ASSERT_NOW(a_found_ok, found_seen, out_o.status == twis_pkg::ST_OK, "found with error")

endmodule

bind trie_word_insert_search twis_checker u_twis_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);

// ===== verif/trie_word_insert_search_tb.sv =====
module trie_word_insert_search_tb;

  // Longest word the stimulus builds, in characters.
  localparam int MAXLEN      = 12;
  localparam int RAND_ITEMS  = 2000;
  // Percent of cycles in which each side idles or stalls.
  localparam int IDLE_PCT    = 37;
  // Items to keep sending once the node pool has run out.
  localparam int AFTER_FULL  = 150;
  // The clearing pass writes all SLOTS edge entries with the input stalled;
  // the limit is a multiple of SLOTS so that pass is not taken for a hang.
  localparam int STUCK_LIMIT = 4 * twis_pkg::SLOTS;
  localparam int TAIL_CYCLES = 20;

  // A word as the stimulus sees it: up to MAXLEN bytes, first byte in ch[0].
  typedef struct packed {
    logic [3:0]             len;
    logic [MAXLEN-1:0][7:0] ch;
  } word_t;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_stall_o;
  twis_pkg::in_t  in_i        = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  twis_pkg::out_t out_o;

  trie_word_insert_search dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the trie, advanced once per accepted item.
  bit [15:0]                     child_of [twis_pkg::SLOTS];
  bit [twis_pkg::NODE_COUNT-1:0] word_ends;
  int                            nodes_used  = 1;
  int                            cur_node    = 0;
  bit                            skip_word   = 1'b0;
  twis_pkg::status_e             skip_status = twis_pkg::ST_OK;
  bit                            pool_full_seen = 1'b0;

  twis_pkg::in_t  pending_chars [$];
  twis_pkg::out_t predicted [$];
  word_t          known_words [$];

  int errors           = 0;
  int stuck_cycles     = 0;
  int chars_sent       = 0;
  int chars_after_full = 0;
  bit item_taken       = 1'b0;
  // Set for a stretch of the run in which neither side idles.
  bit steady_run       = 1'b0;

  // Map a byte to its edge index, or -1 when it is outside the alphabet.
  function automatic int edge_index(logic [7:0] c);
    if (c >= twis_pkg::CH_ZERO && c <= twis_pkg::CH_NINE)
      return int'(c - twis_pkg::CH_ZERO);
    if (c >= twis_pkg::CH_UPPER_A && c <= twis_pkg::CH_UPPER_Z)
      return int'(c - twis_pkg::CH_UPPER_A) + twis_pkg::DIGITS;
    if (c >= twis_pkg::CH_LOWER_A && c <= twis_pkg::CH_LOWER_Z)
      return int'(c - twis_pkg::CH_LOWER_A) + twis_pkg::LOWER_BASE;
    return -1;
  endfunction

  // Advance the shadow trie by one character and return the result it owes.
  function automatic twis_pkg::out_t predict_char(twis_pkg::in_t it);
    twis_pkg::out_t r;
    int   e;
    int   slot;
    int   nxt;
    r.found    = 1'b0;
    r.status   = twis_pkg::ST_OK;
    r.word_end = it.last_char;
    if (skip_word) begin
      // Rest of a failed word: repeat the status that killed it.
      r.status = skip_status;
    end else begin
      e = edge_index(it.char_code);
      if (e < 0) begin
        skip_word   = 1'b1;
        skip_status = twis_pkg::ST_BADCHAR;
        r.status    = twis_pkg::ST_BADCHAR;
      end else begin
        slot = cur_node * twis_pkg::ALPHABET + e;
        nxt  = child_of[slot];
        if (it.opcode == twis_pkg::OP_INSERT) begin
          if (nxt == 0) begin
            if (nodes_used >= twis_pkg::NODE_COUNT) begin
              skip_word      = 1'b1;
              skip_status    = twis_pkg::ST_FULL;
              r.status       = twis_pkg::ST_FULL;
              pool_full_seen = 1'b1;
            end else begin
              nxt = nodes_used;
              nodes_used++;
              child_of[slot] = 16'(nxt);
            end
          end
          // Mark the end whether the node is new or already there.
          if (!skip_word) begin
            cur_node = nxt;
            if (it.last_char) word_ends[nxt] = 1'b1;
          end
        end else begin
          // A missing edge on search is a plain miss, not an error.
          if (nxt == 0) begin
            skip_word   = 1'b1;
            skip_status = twis_pkg::ST_OK;
          end else begin
            cur_node = nxt;
            if (it.last_char) r.found = word_ends[nxt];
          end
        end
      end
    end
    if (it.last_char) begin
      cur_node    = 0;
      skip_word   = 1'b0;
      skip_status = twis_pkg::ST_OK;
    end
    return r;
  endfunction

  // Sample both handshakes on the rising edge; inputs moved on the falling one.
  always @(posedge clk_i) begin : check_results
    twis_pkg::out_t want;
    if (rst_ni) begin
      stuck_cycles++;
      if (in_valid_i && !in_stall_o) begin
        predicted    = {predicted, predict_char(in_i)};
        item_taken   = 1'b1;
        stuck_cycles = 0;
      end
      if (out_valid_o && !out_stall_i) begin
        stuck_cycles = 0;
        if (predicted.size() == 0) begin
          $display("%0t: unexpected item, expected none, got found %0d status %0d word_end %0d",
                   $time, out_o.found, out_o.status, out_o.word_end);
          errors++;
        end else begin
          want = predicted.pop_front();
          if (out_o.found !== want.found) begin
            $display("%0t: found mismatch, expected %0d, got %0d",
                     $time, want.found, out_o.found);
            errors++;
          end
          if (out_o.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_o.status);
            errors++;
          end
          if (out_o.word_end !== want.word_end) begin
            $display("%0t: word_end mismatch, expected %0d, got %0d",
                     $time, want.word_end, out_o.word_end);
            errors++;
          end
        end
      end
    end
  end

  // End the run if nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Drive on the falling edge. Hold the item until it is taken, then
  // advance or idle at random; valid is never tied to the stall.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || item_taken) begin
        item_taken = 1'b0;
        if (pending_chars.size() != 0 &&
            (steady_run || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_i       <= pending_chars.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !steady_run && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  function automatic word_t make_word(string s);
    word_t w;
    w     = '0;
    w.len = 4'(s.len());
    for (int i = 0; i < s.len(); i++) w.ch[i] = s[i];
    return w;
  endfunction

  function automatic logic [7:0] rand_good_char();
    int e;
    e = $urandom_range(0, twis_pkg::ALPHABET - 1);
    if (e < twis_pkg::DIGITS) return twis_pkg::CH_ZERO + 8'(e);
    if (e < twis_pkg::LOWER_BASE) return twis_pkg::CH_UPPER_A + 8'(e - twis_pkg::DIGITS);
    return twis_pkg::CH_LOWER_A + 8'(e - twis_pkg::LOWER_BASE);
  endfunction

  // Half of the bad bytes sit right next to a valid range.
  function automatic logic [7:0] rand_bad_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 5))
        0:       c = twis_pkg::CH_ZERO - 8'd1;
        1:       c = twis_pkg::CH_NINE + 8'd1;
        2:       c = twis_pkg::CH_UPPER_A - 8'd1;
        3:       c = twis_pkg::CH_UPPER_Z + 8'd1;
        4:       c = twis_pkg::CH_LOWER_A - 8'd1;
        default: c = twis_pkg::CH_LOWER_Z + 8'd1;
      endcase
    end
    while (edge_index(c) >= 0) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic word_t fresh_word(int min_len, int max_len);
    word_t w;
    w     = '0;
    w.len = 4'($urandom_range(min_len, max_len));
    for (int i = 0; i < MAXLEN; i++) w.ch[i] = rand_good_char();
    return w;
  endfunction

  // Queue one word, one item per character; a set mask bit makes that
  // character a search. Throttle so the queue stays short.
  task automatic send_word(word_t w, logic [MAXLEN-1:0] search_mask);
    twis_pkg::in_t it;
    for (int i = 0; i < w.len; i++) begin
      it.opcode    = search_mask[i] ? twis_pkg::OP_SEARCH : twis_pkg::OP_INSERT;
      it.char_code = w.ch[i];
      it.last_char = (i == w.len - 1);
      pending_chars = {pending_chars, it};
      chars_sent++;
      if (pool_full_seen) chars_after_full++;
    end
    while (pending_chars.size() > 8) @(posedge clk_i);
  endtask

  // Pause the sender until every owed result has come back.
  task automatic wait_all_results();
    while (pending_chars.size() != 0 || in_valid_i || predicted.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin : stimulus
    word_t w;
    int    roll;
    int    cut;
    bit    mid_pause_done;
    mid_pause_done = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Lowest digit as a one-character word, then look it up.
    w = make_word("0");
    send_word(w, '0);
    known_words = {known_words, w};
    send_word(w, '1);
    // Range ends of upper case, lower case and digits; a prefix is not a word yet.
    w = make_word("Az9");
    send_word(w, '0);
    known_words = {known_words, w};
    send_word(make_word("Az"), '1);
    // Insert over an existing node must still mark the word end.
    w = make_word("Az");
    send_word(w, '0);
    known_words = {known_words, w};
    send_word(make_word("Az"), '1);
    send_word(make_word("Az9"), '1);
    // Bad byte mid word: the rest of the word reports the same error.
    w = make_word("Zxa");
    w.ch[1] = 8'hFF;
    send_word(w, '0);
    // Search miss: rest of the word ignored without error.
    send_word(make_word("qz"), '1);
    // Single bad byte as a whole word.
    w = make_word("x");
    w.ch[0] = twis_pkg::CH_LOWER_Z + 8'd1;
    send_word(w, '1);
    w = make_word("x");
    w.ch[0] = 8'h00;
    send_word(w, '0);
    // Mixed opcodes: insert a known edge, then search a missing one.
    send_word(make_word("0b"), MAXLEN'(2'b10));
    wait_all_results();

    // Random words; keep going until the pool has run dry for a while.
    while (chars_sent < RAND_ITEMS || !pool_full_seen || chars_after_full < AFTER_FULL) begin
      steady_run = (chars_sent >= 600 && chars_sent < 900);
      if (!mid_pause_done && chars_sent >= 1000) begin
        wait_all_results();
        mid_pause_done = 1'b1;
      end
      w    = known_words[$urandom_range(0, known_words.size() - 1)];
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        // Fresh word: grows the trie.
        w = fresh_word(3, MAXLEN);
        send_word(w, '0);
        known_words = {known_words, w};
      end else if (roll < 48) begin
        // Branch off a known word at a random depth.
        cut = $urandom_range(1, w.len);
        for (int i = cut; i < MAXLEN; i++) w.ch[i] = rand_good_char();
        w.len = 4'($urandom_range(cut, MAXLEN));
        send_word(w, '0);
        known_words = {known_words, w};
      end else if (roll < 55) begin
        // Prefix of a known word: node usually exists already.
        w.len = 4'($urandom_range(1, w.len));
        send_word(w, '0);
        known_words = {known_words, w};
      end else if (roll < 72) begin
        send_word(w, '1);
      end else if (roll < 80) begin
        w.len = 4'($urandom_range(1, w.len));
        send_word(w, '1);
      end else if (roll < 86) begin
        send_word(fresh_word(1, MAXLEN), '1);
      end else if (roll < 93) begin
        // Broken word: one bad byte somewhere.
        w.ch[$urandom_range(0, w.len - 1)] = rand_bad_char();
        send_word(w, ($urandom_range(0, 1) == 1) ? '1 : '0);
      end else begin
        send_word(w, MAXLEN'($urandom));
      end
    end
    steady_run = 1'b0;

    wait_all_results();
    // Give a stray extra result time to show up.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== trie_word_insert_search.f =====
+incdir+rtl
rtl/twis_pkg.sv
rtl/twis_ram.sv
rtl/trie_word_insert_search.sv
rtl/twis_checker.sv
verif/trie_word_insert_search_tb.sv
